### design/sbrs_pkg.sv
`default_nettype none

package sbrs_pkg;

    // sample range and field widths
    localparam int SAMPLE_W   = 15;
    localparam int SAMPLE_MAX = 32767;
    localparam int VAL_W      = 16;
    localparam int CNT_W      = 4;
    localparam int MAX_COUNT  = 12;
    localparam int CFG_IDX_W  = 2;

    // datapath widths
    localparam int SPAN_W  = VAL_W + 1;        // distance between two bounds
    localparam int SUM_W   = 19;               // up to 12 samples of 15 bits
    localparam int BASE_W  = 19;               // count times sample maximum
    localparam int OPND_W  = 19;               // shared multiplier operand
    localparam int PROD_W  = 2 * OPND_W;
    localparam int NUM_W   = 38;               // rounded numerator
    localparam int NUMX_W  = NUM_W + 2;        // numerator before truncation
    localparam int QUO_W   = VAL_W;            // mapped offset
    localparam int STEP_W  = 4;                // counts QUO_W divide steps

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOST_LIKELY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd3;

    localparam logic [CNT_W-1:0] COUNT_RESET = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_BASE,
        ST_MUL_P,
        ST_MUL_Q,
        ST_CHECK,
        ST_DIV
    } state_t;

    // which side of the peak is shorter
    typedef enum logic [1:0] {
        SIDE_EVEN,
        SIDE_RIGHT_SHORT,
        SIDE_LEFT_SHORT
    } side_t;

endpackage

`default_nettype wire

### design/skewed_bell_random_shaper.sv
`default_nettype none

// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// sample in | start, busy, uniform_sample             | request taken on start & !busy
// result    | done, shaped_value, remapped            | one-cycle strobe, no back-pressure
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | written on cfg_valid & cfg_ready
//
// a request that does not complete an average is absorbed in its own cycle, busy stays low
// a completing request holds busy for three passes through the shared 19x19
// multiplier, one compare/numerator step and 16 restoring divide steps; done strobes
// in the cycle in which busy is low again, when the next request may already be taken
// long-side average: busy for multiplies and compare, no result; extra sample: full pass
// equal bounds strobe next cycle; results never stall; rst_n async, config back to 0/0/0/3

module skewed_bell_random_shaper (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [sbrs_pkg::SAMPLE_W-1:0]       uniform_sample,
    output logic                                done,
    output logic signed [sbrs_pkg::VAL_W-1:0]   shaped_value,
    output logic                                remapped,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [sbrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [sbrs_pkg::VAL_W-1:0]          cfg_data
);

    localparam int SAMPLE_W = sbrs_pkg::SAMPLE_W;
    localparam int VAL_W    = sbrs_pkg::VAL_W;
    localparam int CNT_W    = sbrs_pkg::CNT_W;
    localparam int SPAN_W   = sbrs_pkg::SPAN_W;
    localparam int SUM_W    = sbrs_pkg::SUM_W;
    localparam int BASE_W   = sbrs_pkg::BASE_W;
    localparam int OPND_W   = sbrs_pkg::OPND_W;
    localparam int PROD_W   = sbrs_pkg::PROD_W;
    localparam int NUM_W    = sbrs_pkg::NUM_W;
    localparam int NUMX_W   = sbrs_pkg::NUMX_W;
    localparam int QUO_W    = sbrs_pkg::QUO_W;
    localparam int STEP_W   = sbrs_pkg::STEP_W;

    localparam logic [SAMPLE_W-1:0] SMAX = SAMPLE_W'(sbrs_pkg::SAMPLE_MAX);
    localparam logic [CNT_W-1:0]    CMAX = CNT_W'(sbrs_pkg::MAX_COUNT);

    // configuration registers
    logic signed [VAL_W-1:0] low_bound_reg;
    logic signed [VAL_W-1:0] most_likely_reg;
    logic signed [VAL_W-1:0] high_bound_reg;
    logic [CNT_W-1:0]        sample_count_reg;

    // sequencer and accumulation state
    sbrs_pkg::state_t state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    taken_reg, taken_next;
    logic                awaiting_reg, awaiting_next;
    logic                extra_reg, extra_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;

    // shared unit operands and results
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [PROD_W-1:0]  p_reg, p_next;
    logic [PROD_W-1:0]  q_reg, q_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   den_reg, den_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // result register
    logic                    done_reg, done_next;
    logic signed [VAL_W-1:0] shaped_reg, shaped_next;
    logic                    remapped_reg, remapped_next;

    // effective geometry
    logic signed [VAL_W-1:0] hi_eff;
    logic signed [VAL_W-1:0] pk_eff;
    logic [SPAN_W-1:0]       l_span;
    logic [SPAN_W-1:0]       r_span;
    logic [SPAN_W-1:0]       span_sum;
    logic                    bounds_equal;
    sbrs_pkg::side_t         side;
    logic [CNT_W-1:0]        count_eff;
    logic [CNT_W-1:0]        taken_inc;

    logic [OPND_W-1:0]  mul_a;
    logic [OPND_W-1:0]  mul_b;
    logic [PROD_W-1:0]  mul_prod;

    logic [PROD_W:0]    two_p;
    logic [PROD_W:0]    q_ext;
    logic [NUMX_W-1:0]  num_full;
    logic               remap_hit;
    logic               div_ge;
    logic [QUO_W-1:0]   quo_shift;

    // clamp the bounds: high below low acts as low, peak pulled inside
    always_comb
    begin
        hi_eff = (high_bound_reg < low_bound_reg) ? low_bound_reg : high_bound_reg;
        if (most_likely_reg < low_bound_reg)
        begin
            pk_eff = low_bound_reg;
        end
        else if (most_likely_reg > hi_eff)
        begin
            pk_eff = hi_eff;
        end
        else
        begin
            pk_eff = most_likely_reg;
        end
    end

    // spans are never negative after clamping
    assign l_span   = SPAN_W'({pk_eff[VAL_W-1], pk_eff}) -
                      SPAN_W'({low_bound_reg[VAL_W-1], low_bound_reg});
    assign r_span   = SPAN_W'({hi_eff[VAL_W-1], hi_eff}) -
                      SPAN_W'({pk_eff[VAL_W-1], pk_eff});
    assign span_sum = l_span + r_span;
    assign bounds_equal = (hi_eff == low_bound_reg);

    always_comb
    begin
        if (r_span < l_span)
        begin
            side = sbrs_pkg::SIDE_RIGHT_SHORT;
        end
        else if (l_span < r_span)
        begin
            side = sbrs_pkg::SIDE_LEFT_SHORT;
        end
        else
        begin
            side = sbrs_pkg::SIDE_EVEN;
        end
    end

    // count of zero acts as one, above twelve acts as twelve
    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (sample_count_reg > CMAX)
        begin
            count_eff = CMAX;
        end
        else
        begin
            count_eff = sample_count_reg;
        end
    end

    assign taken_inc = taken_reg + CNT_W'(1);

    // the shared multiplier
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // long-side test and rounded numerator: 4P + base, minus or plus 2Q
    assign two_p = {p_reg, 1'b0};
    assign q_ext = {1'b0, q_reg};

    always_comb
    begin
        remap_hit = 1'b0;
        if (!extra_reg)
        begin
            if (side == sbrs_pkg::SIDE_RIGHT_SHORT)
            begin
                remap_hit = (two_p > q_ext);
            end
            else if (side == sbrs_pkg::SIDE_LEFT_SHORT)
            begin
                remap_hit = (two_p < q_ext);
            end
        end
    end

    always_comb
    begin
        num_full = {p_reg, 2'b00} + NUMX_W'(base_reg);
        if (!extra_reg && side == sbrs_pkg::SIDE_LEFT_SHORT)
        begin
            num_full = num_full - {1'b0, q_reg, 1'b0};
        end
        else if (extra_reg && side == sbrs_pkg::SIDE_RIGHT_SHORT)
        begin
            num_full = num_full + {1'b0, q_reg, 1'b0};
        end
    end

    // one restoring divide step
    assign div_ge    = (rem_reg >= den_reg);
    assign quo_shift = {quo_reg[QUO_W-2:0], div_ge};

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        taken_next    = taken_reg;
        awaiting_next = awaiting_reg;
        extra_next    = extra_reg;
        x_next        = x_reg;
        base_next     = base_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        done_next     = 1'b0;
        shaped_next   = shaped_reg;
        remapped_next = remapped_reg;
        mul_a         = '0;
        mul_b         = '0;

        case (state_reg)
            sbrs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (bounds_equal)
                    begin
                        // degenerate range: emit the bound at once
                        done_next     = 1'b1;
                        shaped_next   = low_bound_reg;
                        remapped_next = 1'b0;
                        sum_next      = '0;
                        taken_next    = '0;
                        awaiting_next = 1'b0;
                    end
                    else if (awaiting_reg)
                    begin
                        extra_next = 1'b1;
                        x_next     = uniform_sample;
                        state_next = sbrs_pkg::ST_MUL_BASE;
                    end
                    else
                    begin
                        sum_next   = sum_reg + SUM_W'(uniform_sample);
                        taken_next = taken_inc;
                        extra_next = 1'b0;
                        if (taken_inc >= count_eff)
                        begin
                            state_next = sbrs_pkg::ST_MUL_BASE;
                        end
                    end
                end
            end

            sbrs_pkg::ST_MUL_BASE:
            begin
                // base = count * max, a single sample for the extra draw
                mul_a      = extra_reg ? OPND_W'(1) : OPND_W'(taken_reg);
                mul_b      = OPND_W'(SMAX);
                base_next  = mul_prod[BASE_W-1:0];
                state_next = sbrs_pkg::ST_MUL_P;
            end

            sbrs_pkg::ST_MUL_P:
            begin
                if (!extra_reg)
                begin
                    mul_a = (side == sbrs_pkg::SIDE_LEFT_SHORT) ? OPND_W'(r_span)
                                                                : OPND_W'(l_span);
                    mul_b = OPND_W'(sum_reg);
                end
                else
                begin
                    mul_a = (side == sbrs_pkg::SIDE_RIGHT_SHORT) ? OPND_W'(r_span)
                                                                 : OPND_W'(l_span);
                    mul_b = (side == sbrs_pkg::SIDE_LEFT_SHORT) ? OPND_W'(SMAX - x_reg)
                                                                : OPND_W'(x_reg);
                end
                p_next     = mul_prod;
                state_next = sbrs_pkg::ST_MUL_Q;
            end

            sbrs_pkg::ST_MUL_Q:
            begin
                mul_a = OPND_W'(base_reg);
                case (side)
                    sbrs_pkg::SIDE_RIGHT_SHORT:
                    begin
                        mul_b = extra_reg ? OPND_W'(l_span - r_span) : OPND_W'(span_sum);
                    end
                    sbrs_pkg::SIDE_LEFT_SHORT:
                    begin
                        mul_b = extra_reg ? '0 : OPND_W'(r_span - l_span);
                    end
                    default:
                    begin
                        mul_b = '0;
                    end
                endcase
                q_next     = mul_prod;
                state_next = sbrs_pkg::ST_CHECK;
            end

            sbrs_pkg::ST_CHECK:
            begin
                if (remap_hit)
                begin
                    // average fell on the long side: wait for one more sample
                    awaiting_next = 1'b1;
                    sum_next      = '0;
                    taken_next    = '0;
                    state_next    = sbrs_pkg::ST_IDLE;
                end
                else
                begin
                    rem_next   = num_full[NUM_W-1:0];
                    den_next   = NUM_W'({base_reg, 1'b0}) << (QUO_W - 1);
                    quo_next   = '0;
                    step_next  = STEP_W'(QUO_W - 1);
                    state_next = sbrs_pkg::ST_DIV;
                end
            end

            sbrs_pkg::ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - den_reg;
                end
                quo_next  = quo_shift;
                den_next  = den_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    done_next     = 1'b1;
                    shaped_next   = low_bound_reg + quo_shift;
                    remapped_next = extra_reg;
                    sum_next      = '0;
                    taken_next    = '0;
                    awaiting_next = 1'b0;
                    state_next    = sbrs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sbrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sbrs_pkg::ST_IDLE;
            sum_reg      <= '0;
            taken_reg    <= '0;
            awaiting_reg <= 1'b0;
            extra_reg    <= 1'b0;
            done_reg     <= 1'b0;
            remapped_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            taken_reg    <= taken_next;
            awaiting_reg <= awaiting_next;
            extra_reg    <= extra_next;
            done_reg     <= done_next;
            remapped_reg <= remapped_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        base_reg   <= base_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        shaped_reg <= shaped_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg    <= '0;
            most_likely_reg  <= '0;
            high_bound_reg   <= '0;
            sample_count_reg <= sbrs_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sbrs_pkg::REG_LOW_BOUND:    low_bound_reg    <= cfg_data;
                sbrs_pkg::REG_MOST_LIKELY:  most_likely_reg  <= cfg_data;
                sbrs_pkg::REG_HIGH_BOUND:   high_bound_reg   <= cfg_data;
                sbrs_pkg::REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[CNT_W-1:0];
                default:                    low_bound_reg    <= low_bound_reg;
            endcase
        end
    end

    assign busy         = (state_reg != sbrs_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign shaped_value = shaped_reg;
    assign remapped     = remapped_reg;

    // a result is only strobed once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == sbrs_pkg::ST_IDLE))
        else $error("result strobe while sequencer busy");

    // a pending extra sample never carries a partial sum
    a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (taken_reg == '0 && sum_reg == '0))
        else $error("partial sum kept with extra sample pending");

    // at rest the sample count is always below twelve
    a_taken_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbrs_pkg::ST_IDLE) |-> (taken_reg < CMAX))
        else $error("sample count at rest out of range");

    // a remapped result only comes out of the divider
    a_remap_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && remapped_reg) |-> ($past(state_reg) == sbrs_pkg::ST_DIV))
        else $error("remapped result without divide");

    // the divider always ends its run before the sequencer leaves it
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbrs_pkg::ST_DIV && step_reg != '0) |=>
            (state_reg == sbrs_pkg::ST_DIV))
        else $error("divide run cut short");

endmodule

`default_nettype wire

### tb/sv/tb_skewed_bell_random_shaper.sv
`timescale 1ns / 1ps

module tb_skewed_bell_random_shaper;

    // pause before a register write: covers the mapping pass plus the hold
    // after a long-side average, with margin
    localparam int SETTLE_CYCLES = 32;
    // cycles let pass after the last expected result
    localparam int DRAIN_CYCLES  = 40;
    // cycles without any handshake or strobe before the run is abandoned
    localparam int QUIET_LIMIT   = 2000;
    // random sample requests after the directed table
    localparam int RANDOM_ITEMS  = 1950;

    // one shaped result as the block reports it
    typedef struct packed {
        logic signed [sbrs_pkg::VAL_W-1:0] value;
        logic                              flag;
    } shaped_t;

    typedef enum logic {
        ROW_REG,
        ROW_SAMPLE
    } row_kind_t;

    // one row of the directed table: a register write or a sample request,
    // the latter optionally with its result typed in
    typedef struct {
        row_kind_t                      kind;
        logic [sbrs_pkg::CFG_IDX_W-1:0] index;
        logic [sbrs_pkg::VAL_W-1:0]     data;
        bit                             pinned;
        shaped_t                        pin;
    } stim_row_t;

    // ------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------
    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [sbrs_pkg::SAMPLE_W-1:0]     uniform_sample;
    logic                              done;
    logic signed [sbrs_pkg::VAL_W-1:0] shaped_value;
    logic                              remapped;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [sbrs_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [sbrs_pkg::VAL_W-1:0]        cfg_data;

    skewed_bell_random_shaper dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .uniform_sample (uniform_sample),
        .done           (done),
        .shaped_value   (shaped_value),
        .remapped       (remapped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: its own copy of the registers and the accumulator
    // ------------------------------------------------------------------
    logic [sbrs_pkg::VAL_W-1:0] reg_low   = '0;
    logic [sbrs_pkg::VAL_W-1:0] reg_peak  = '0;
    logic [sbrs_pkg::VAL_W-1:0] reg_high  = '0;
    logic [sbrs_pkg::CNT_W-1:0] reg_count = sbrs_pkg::COUNT_RESET;
    longint                     acc_sum   = 0;
    logic [sbrs_pkg::CNT_W-1:0] acc_taken = '0;
    bit                         extra_due = 1'b0;

    // results still to come, oldest first
    shaped_t shaped_q[$];
    int      mismatches = 0;

    // a typed-in result rides along with the request that should cause it
    bit      pin_valid;
    shaped_t pin_item;

    stim_row_t stim_rows[$];

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint floor_div(input longint num, input longint den);
        if (num < 0 || den <= 0)
            return 0;
        return num / den;
    endfunction

    function automatic void clear_acc();
        acc_sum   = 0;
        acc_taken = '0;
        extra_due = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [sbrs_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [sbrs_pkg::VAL_W-1:0] d);
        case (idx)
            sbrs_pkg::REG_LOW_BOUND:    reg_low   = d;
            sbrs_pkg::REG_MOST_LIKELY:  reg_peak  = d;
            sbrs_pkg::REG_HIGH_BOUND:   reg_high  = d;
            sbrs_pkg::REG_SAMPLE_COUNT: reg_count = d[sbrs_pkg::CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // takes one sample, returns 1 when it completes a result
    function automatic bit shape_sample(input logic [sbrs_pkg::SAMPLE_W-1:0] x_in,
                                        output shaped_t res);
        longint m, lo, hi, pk, x, l_span, r_span, k, c, s, cm;
        int     n;
        m   = sbrs_pkg::SAMPLE_MAX;
        lo  = longint'($signed(reg_low));
        hi  = longint'($signed(reg_high));
        pk  = longint'($signed(reg_peak));
        x   = longint'(x_in);
        res = '0;
        if (x > m)
            x = m;
        // bounds out of order collapse onto the low bound, peak is clamped
        if (hi < lo)
            hi = lo;
        if (pk < lo)
            pk = lo;
        if (pk > hi)
            pk = hi;
        l_span = pk - lo;
        r_span = hi - pk;

        // equal bounds: the bound itself, at once, accumulator cleared
        if (hi == lo)
        begin
            clear_acc();
            res.value = sbrs_pkg::VAL_W'(lo);
            return 1'b1;
        end

        // extra sample remapped onto the short side of the present setting
        if (extra_due)
        begin
            if (r_span < l_span)
                k = floor_div(2 * l_span * m + (4 * x - 2 * m) * r_span + m, 2 * m);
            else if (l_span < r_span)
                k = floor_div(4 * l_span * (m - x) + m, 2 * m);
            else
                k = floor_div(4 * l_span * x + m, 2 * m);
            clear_acc();
            res.value = sbrs_pkg::VAL_W'(lo + k);
            res.flag  = 1'b1;
            return 1'b1;
        end

        acc_sum   = acc_sum + x;
        acc_taken = acc_taken + 1'b1;
        n = int'(reg_count);
        if (n < 1)
            n = 1;
        if (n > sbrs_pkg::MAX_COUNT)
            n = sbrs_pkg::MAX_COUNT;
        if (int'(acc_taken) < n)
            return 1'b0;

        c  = longint'(acc_taken);
        s  = acc_sum;
        cm = c * m;
        if (r_span < l_span)
        begin
            // average beyond the mirror of the short side: wait for one more
            if (2 * l_span * s > cm * (l_span + r_span))
            begin
                acc_sum   = 0;
                acc_taken = '0;
                extra_due = 1'b1;
                return 1'b0;
            end
            k = floor_div(4 * l_span * s + cm, 2 * cm);
        end
        else if (l_span < r_span)
        begin
            if (2 * r_span * s < cm * (r_span - l_span))
            begin
                acc_sum   = 0;
                acc_taken = '0;
                extra_due = 1'b1;
                return 1'b0;
            end
            k = floor_div(4 * r_span * s - 2 * cm * (r_span - l_span) + cm, 2 * cm);
        end
        else
        begin
            k = floor_div(4 * l_span * s + cm, 2 * cm);
        end
        clear_acc();
        res.value = sbrs_pkg::VAL_W'(lo + k);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // everything is sampled at the rising edge, before the block updates
    always @(posedge clk)
    begin : scoreboard
        shaped_t want;
        shaped_t pred;
        bit      has_result;
        if (rst_n)
        begin
            // a strobe consumes the oldest expectation
            if (done)
            begin
                if (shaped_q.size() == 0)
                    report_mismatch($sformatf("result %0d/%0b with nothing expected",
                                              shaped_value, remapped));
                else
                begin
                    want = shaped_q.pop_front();
                    if (shaped_value !== want.value)
                        report_mismatch($sformatf("shaped_value got %0d want %0d",
                                                  shaped_value, want.value));
                    if (remapped !== want.flag)
                        report_mismatch($sformatf("remapped got %0b want %0b",
                                                  remapped, want.flag));
                end
            end
            // accepted sample request: run the predictor, keep its state in step
            if (start && !busy)
            begin
                has_result = shape_sample(uniform_sample, pred);
                if (pin_valid)
                    shaped_q.push_back(pin_item);
                else if (has_result)
                    shaped_q.push_back(pred);
            end
            // register write taken
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_skewed_bell_random_shaper failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // driving: inputs change on the falling edge only
    // ------------------------------------------------------------------
    // holds the request until the block takes it; start stays high afterwards
    // so that back-to-back requests need no extra edge
    task automatic send_sample(input logic [sbrs_pkg::SAMPLE_W-1:0] x, input bit pinned,
                               input shaped_t pin);
        @(negedge clk);
        start          <= 1'b1;
        uniform_sample <= x;
        pin_valid      <= pinned;
        pin_item       <= pin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start     <= 1'b0;
            pin_valid <= 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    // register writes happen only with the block idle: nothing outstanding,
    // then a settle pause in case a long-side average is still being checked
    task automatic write_reg(input logic [sbrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sbrs_pkg::VAL_W-1:0] d);
        @(negedge clk);
        start     <= 1'b0;
        pin_valid <= 1'b0;
        while (shaped_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------
    function automatic stim_row_t reg_row(input logic [sbrs_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [sbrs_pkg::VAL_W-1:0] d);
        stim_row_t r;
        r.kind   = ROW_REG;
        r.index  = idx;
        r.data   = d;
        r.pinned = 1'b0;
        r.pin    = '0;
        return r;
    endfunction

    function automatic stim_row_t sample_row(input logic [sbrs_pkg::SAMPLE_W-1:0] x);
        stim_row_t r;
        r.kind   = ROW_SAMPLE;
        r.index  = '0;
        r.data   = sbrs_pkg::VAL_W'(x);
        r.pinned = 1'b0;
        r.pin    = '0;
        return r;
    endfunction

    function automatic stim_row_t pinned_row(input logic [sbrs_pkg::SAMPLE_W-1:0] x,
                                             input logic signed [sbrs_pkg::VAL_W-1:0] v,
                                             input logic f);
        stim_row_t r;
        r           = sample_row(x);
        r.pinned    = 1'b1;
        r.pin.value = v;
        r.pin.flag  = f;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t                     row;
        int                            random_sent;
        int                            burst_left;
        int                            phase_len;
        int                            shape_kind;
        int                            lo_v, hi_v, pk_v;
        int                            sel;
        bit                            steady;
        logic [sbrs_pkg::VAL_W-1:0]    cnt_d;
        logic [sbrs_pkg::SAMPLE_W-1:0] x_v;

        // every input known from time zero
        rst_n          = 1'b0;
        start          = 1'b0;
        uniform_sample = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pin_valid      = 1'b0;
        pin_item       = '0;

        // after reset all bounds are zero: equal bounds, zero out at once
        stim_rows.push_back(pinned_row(15'd0, 16'sd0, 1'b0));
        stim_rows.push_back(pinned_row(15'd32767, 16'sd0, 1'b0));
        // full range, right side one shorter, single-sample average
        stim_rows.push_back(reg_row(sbrs_pkg::REG_LOW_BOUND, 16'h8000));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_HIGH_BOUND, 16'h7FFF));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_SAMPLE_COUNT, 16'h0001));
        stim_rows.push_back(pinned_row(15'd0, 16'sh8000, 1'b0));
        // top sample lands on the long side: extra request remaps it
        stim_rows.push_back(sample_row(15'd32767));
        stim_rows.push_back(pinned_row(15'd32767, 16'sh7FFF, 1'b1));
        stim_rows.push_back(sample_row(15'd32767));
        stim_rows.push_back(pinned_row(15'd0, 16'sh8001, 1'b1));
        // peak at the low bound: left side empty
        stim_rows.push_back(reg_row(sbrs_pkg::REG_MOST_LIKELY, 16'h8000));
        stim_rows.push_back(pinned_row(15'd32767, 16'sh7FFF, 1'b0));
        stim_rows.push_back(sample_row(15'd0));
        stim_rows.push_back(pinned_row(15'd0, 16'sh8000, 1'b1));
        // count of zero behaves as one
        stim_rows.push_back(reg_row(sbrs_pkg::REG_SAMPLE_COUNT, 16'h0000));
        stim_rows.push_back(pinned_row(15'd32767, 16'sh7FFF, 1'b0));
        // count of fifteen behaves as twelve, then lowered mid-accumulation
        stim_rows.push_back(reg_row(sbrs_pkg::REG_SAMPLE_COUNT, 16'hFFFF));
        stim_rows.push_back(sample_row(15'd32767));
        stim_rows.push_back(sample_row(15'd32767));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_SAMPLE_COUNT, 16'h0002));
        stim_rows.push_back(sample_row(15'd32767));
        // small symmetric range
        stim_rows.push_back(reg_row(sbrs_pkg::REG_LOW_BOUND, 16'hFFF6));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_MOST_LIKELY, 16'h0000));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_HIGH_BOUND, 16'h000A));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_SAMPLE_COUNT, 16'h0001));
        stim_rows.push_back(pinned_row(15'd0, -16'sd10, 1'b0));
        stim_rows.push_back(pinned_row(15'd32767, 16'sd10, 1'b0));
        stim_rows.push_back(sample_row(15'd16384));
        // high bound below low bound: collapses onto the low bound
        stim_rows.push_back(reg_row(sbrs_pkg::REG_LOW_BOUND, 16'h0064));
        stim_rows.push_back(pinned_row(15'd12345, 16'sd100, 1'b0));
        // equal bounds part way through an average clear the accumulator
        stim_rows.push_back(reg_row(sbrs_pkg::REG_LOW_BOUND, 16'hFFF6));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_MOST_LIKELY, 16'h0005));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_SAMPLE_COUNT, 16'h0003));
        stim_rows.push_back(sample_row(15'd1000));
        stim_rows.push_back(sample_row(15'd30000));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_HIGH_BOUND, 16'hFFF6));
        stim_rows.push_back(pinned_row(15'd22222, -16'sd10, 1'b0));
        // extra sample pending while the sides become even
        stim_rows.push_back(reg_row(sbrs_pkg::REG_HIGH_BOUND, 16'h000A));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_SAMPLE_COUNT, 16'h0001));
        stim_rows.push_back(sample_row(15'd32767));
        stim_rows.push_back(reg_row(sbrs_pkg::REG_MOST_LIKELY, 16'h0000));
        stim_rows.push_back(sample_row(15'd20000));
        // peak below the low bound is clamped onto it
        stim_rows.push_back(reg_row(sbrs_pkg::REG_MOST_LIKELY, 16'hFF00));
        stim_rows.push_back(sample_row(15'd5000));
        stim_rows.push_back(sample_row(15'h5555));

        // reset held from time zero, released on a falling edge
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.index, row.data);
            else
                send_sample(row.data[sbrs_pkg::SAMPLE_W-1:0], row.pinned, row.pin);
        end

        // random part: a fresh setting per phase, then a run of samples
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            shape_kind = int'($urandom_range(0, 9));
            lo_v = int'($urandom_range(0, 65535)) - 32768;
            case (shape_kind)
                0:
                begin
                    // equal bounds
                    hi_v = lo_v;
                    pk_v = int'($urandom_range(0, 65535)) - 32768;
                end
                1:
                begin
                    // anything goes, bounds in any order
                    hi_v = int'($urandom_range(0, 65535)) - 32768;
                    pk_v = int'($urandom_range(0, 65535)) - 32768;
                end
                2:
                begin
                    // widest range, peak at either end or anywhere
                    lo_v = -32768;
                    hi_v = 32767;
                    sel  = int'($urandom_range(0, 2));
                    pk_v = (sel == 0) ? -32768 :
                           (sel == 1) ? 32767 : int'($urandom_range(0, 65535)) - 32768;
                end
                default:
                begin
                    // well-formed, mostly narrow so the rounding shows
                    if ($urandom_range(0, 3) == 0)
                        hi_v = lo_v + int'($urandom_range(1, 65535));
                    else
                        hi_v = lo_v + int'($urandom_range(1, 200));
                    if (hi_v > 32767)
                        hi_v = 32767;
                    sel = int'($urandom_range(0, 4));
                    if (sel == 0)
                        pk_v = lo_v;
                    else if (sel == 1)
                        pk_v = hi_v;
                    else
                        pk_v = lo_v + int'($urandom_range(0, hi_v - lo_v));
                end
            endcase
            // count mostly in range, now and then zero or above twelve;
            // upper data bits are noise
            cnt_d = sbrs_pkg::VAL_W'($urandom);
            if ($urandom_range(0, 7) == 0)
                cnt_d[sbrs_pkg::CNT_W-1:0] = sbrs_pkg::CNT_W'($urandom_range(0, 15));
            else
                cnt_d[sbrs_pkg::CNT_W-1:0] =
                    sbrs_pkg::CNT_W'($urandom_range(1, sbrs_pkg::MAX_COUNT));

            write_reg(sbrs_pkg::REG_LOW_BOUND, sbrs_pkg::VAL_W'(lo_v));
            write_reg(sbrs_pkg::REG_MOST_LIKELY, sbrs_pkg::VAL_W'(pk_v));
            write_reg(sbrs_pkg::REG_HIGH_BOUND, sbrs_pkg::VAL_W'(hi_v));
            write_reg(sbrs_pkg::REG_SAMPLE_COUNT, cnt_d);

            // some phases run flat out, the rest in bursts with gaps
            steady     = ($urandom_range(0, 3) == 0);
            phase_len  = int'($urandom_range(20, 70));
            burst_left = 0;
            for (int j = 0; j < phase_len; j++)
            begin
                if (burst_left == 0)
                begin
                    hold_off(steady ? 0 : int'($urandom_range(0, 8)));
                    burst_left = int'($urandom_range(1, 16));
                end
                sel = int'($urandom_range(0, 9));
                if (sel == 0)
                    x_v = '0;
                else if (sel == 1)
                    x_v = sbrs_pkg::SAMPLE_W'(sbrs_pkg::SAMPLE_MAX);
                else
                    x_v = sbrs_pkg::SAMPLE_W'($urandom_range(0, sbrs_pkg::SAMPLE_MAX));
                send_sample(x_v, 1'b0, '0);
                burst_left--;
                random_sent++;
                // now and then a register changes part way through an average
                // or while an extra sample is pending
                if ($urandom_range(0, 49) == 0)
                    write_reg(sbrs_pkg::CFG_IDX_W'($urandom_range(0, 3)),
                              sbrs_pkg::VAL_W'($urandom));
            end
        end

        // drain: everything expected must arrive, then let the block settle
        @(negedge clk);
        start     <= 1'b0;
        pin_valid <= 1'b0;
        while (shaped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("tb_skewed_bell_random_shaper passed");
        else
            $display("tb_skewed_bell_random_shaper failed");
        $finish;
    end

endmodule

### filelist.f
design/sbrs_pkg.sv
design/skewed_bell_random_shaper.sv
tb/sv/tb_skewed_bell_random_shaper.sv
